// ===== design/hsv_to_rgb_converter_core_macros.svh =====
// Assertion macros for the HSV to RGB converter core.
// Used by hsv_to_rgb_converter_core.sv; expects clk and arst_n in scope.
`ifndef HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HSV_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsv_to_rgb assertion failed");

// next-cycle implication, disabled while in reset
`define HSV_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsv_to_rgb assertion failed");

`endif

// ===== design/hsv2rgb_pkg.sv =====
// Shared types and fixed constants for the HSV to RGB converter.
// No dependencies.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

	typedef logic [2:0] sector_t;

	// 60-degree hue sectors
	localparam sector_t SEC_RED_YEL = 3'd0;
	localparam sector_t SEC_YEL_GRN = 3'd1;
	localparam sector_t SEC_GRN_CYN = 3'd2;
	localparam sector_t SEC_CYN_BLU = 3'd3;
	localparam sector_t SEC_BLU_MAG = 3'd4;
	localparam sector_t SEC_MAG_RED = 3'd5;

	localparam int CHAN_W = 8;
	// 255 full scale; 255/60 = 17/4, so the secondary channel scales by 17
	localparam int SCALE_FULL = 255;
	localparam int SCALE_SEC  = 17;

endpackage

// ===== design/hsv_to_rgb_converter_core.sv =====
// HSV to RGB converter core, top level: five-stage pipeline, one word per clock.
// Depends on hsv2rgb_pkg.sv and hsv_to_rgb_converter_core_macros.svh.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_core_macros.svh"

// Usage
//   Input channel: drive hue, saturation, brightness and raise start. A word is
//   taken at every rising edge with start high and busy low. busy is always low:
//   the pipeline never stalls, so a new word may be offered every clock.
//   Output channel: red, green, blue are valid for exactly one cycle while done
//   is high. The receiver cannot hold results off and none is needed.
//   A taken word passes the stage registers s1 to s5 in order, and done
//   is the stage-5 valid bit. Throughput is one word per clock.
//   Stages: 1 clamp and hue wrap, 2 sector decode and v*s product,
//   3 distance to sector center and chroma/offset channels,
//   4 product of v*s and distance, 5 secondary channel and channel select.
//   The clock rate is set by the stage-4 multiplier and the stage-5
//   subtract and scale.
//   Reset: arst_n low clears all valid bits at once; words in flight are
//   dropped and done stays low until new words arrive.
//   Math: saturation and value above 1.0 clamp to 1.0; hue at or past 360
//   degrees wraps once. Every channel is exact, truncated to 0..255.

module hsv_to_rgb_converter_core #(
	parameter int HUE_FRAC_BITS  = 6,
	parameter int UNIT_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [HUE_FRAC_BITS+8:0]      hue,
	input  logic [UNIT_FRAC_BITS:0]       saturation,
	input  logic [UNIT_FRAC_BITS:0]       brightness,
	output logic                          done,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] red,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] green,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] blue
);

	import hsv2rgb_pkg::*;

	localparam int HW  = HUE_FRAC_BITS + 9;       // hue width
	localparam int UW  = UNIT_FRAC_BITS + 1;      // unit fraction width
	localparam int PW  = 2 * UNIT_FRAC_BITS + 1;  // v*s width
	localparam int NW  = PW + HW;                 // common scale ONE*ONE*W
	localparam int XW  = NW + 5;                  // after scaling by 17
	localparam int XSH = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS + 2;

	localparam int SECTOR_W = 60 << HUE_FRAC_BITS;

	localparam logic [HW-1:0] W1    = HW'(SECTOR_W);
	localparam logic [HW-1:0] W2    = HW'(2 * SECTOR_W);
	localparam logic [HW-1:0] W3    = HW'(3 * SECTOR_W);
	localparam logic [HW-1:0] W4    = HW'(4 * SECTOR_W);
	localparam logic [HW-1:0] W5    = HW'(5 * SECTOR_W);
	localparam logic [HW-1:0] WFULL = HW'(6 * SECTOR_W);
	localparam logic [UW-1:0] ONE   = UW'(1 << UNIT_FRAC_BITS);

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage 1
	logic [HW-1:0] h_s1;
	logic [UW-1:0] s_s1, v_s1;
	// stage 2
	sector_t       sec_s2;
	logic [HW-1:0] pos_s2;
	logic [PW-1:0] p_s2;
	logic [UW-1:0] v_s2;
	// stage 3
	sector_t           sec_s3;
	logic [HW-1:0]     dist_s3;
	logic [PW-1:0]     p_s3;
	logic [UW-1:0]     v_s3;
	logic [CHAN_W-1:0] c_s3, m_s3;
	// stage 4
	sector_t           sec_s4;
	logic [NW-1:0]     q_s4, vw_s4;
	logic [CHAN_W-1:0] c_s4, m_s4;
	// stage 5 (output)
	logic [CHAN_W-1:0] red_s5, green_s5, blue_s5;

	// combinational
	logic [HW-1:0]      hue_c, base_c, dist_c;
	logic [UW-1:0]      sat_c, val_c;
	sector_t            sec_c;
	logic [PW-1:0]      vo_c;
	logic [PW+7:0]      m_full_c;
	logic [UW+7:0]      c_full_c;
	logic [NW-1:0]      n_c;
	logic [XW-1:0]      x_full_c;
	logic [CHAN_W-1:0]  x_c;
	logic [CHAN_W-1:0]  r_c, g_c, b_c;

	// clamp to 1.0 and wrap hue once
	always_comb begin
		sat_c = (saturation > ONE) ? ONE : saturation;
		val_c = (brightness > ONE) ? ONE : brightness;
		hue_c = (hue >= WFULL) ? hue - WFULL : hue;
	end

	// sector decode; exact boundary belongs to the upper sector
	always_comb begin
		if (h_s1 >= W5)      sec_c = SEC_MAG_RED;
		else if (h_s1 >= W4) sec_c = SEC_BLU_MAG;
		else if (h_s1 >= W3) sec_c = SEC_CYN_BLU;
		else if (h_s1 >= W2) sec_c = SEC_GRN_CYN;
		else if (h_s1 >= W1) sec_c = SEC_YEL_GRN;
		else                 sec_c = SEC_RED_YEL;

		if (h_s1 >= W4)      base_c = W4;
		else if (h_s1 >= W2) base_c = W2;
		else                 base_c = '0;
	end

	// |pos - W|, chroma channel 255*v/ONE, offset channel 255*(v*ONE - p)/ONE^2
	always_comb begin
		dist_c   = (pos_s2 >= W1) ? pos_s2 - W1 : W1 - pos_s2;
		vo_c     = (PW'(v_s2) << UNIT_FRAC_BITS) - p_s2;
		m_full_c = (PW + 8)'(vo_c) * (PW + 8)'(SCALE_FULL);
		c_full_c = (UW + 8)'(v_s2) * (UW + 8)'(SCALE_FULL);
	end

	// secondary channel: 17*(v*ONE*W - p*dist) / (ONE^2 * 2^H * 4)
	always_comb begin
		n_c      = vw_s4 - q_s4;
		x_full_c = XW'(n_c) * XW'(SCALE_SEC);
		x_c      = x_full_c[XSH+7:XSH];
	end

	always_comb begin
		case (sec_s4)
			SEC_RED_YEL: begin r_c = c_s4; g_c = x_c;  b_c = m_s4; end
			SEC_YEL_GRN: begin r_c = x_c;  g_c = c_s4; b_c = m_s4; end
			SEC_GRN_CYN: begin r_c = m_s4; g_c = c_s4; b_c = x_c;  end
			SEC_CYN_BLU: begin r_c = m_s4; g_c = x_c;  b_c = c_s4; end
			SEC_BLU_MAG: begin r_c = x_c;  g_c = m_s4; b_c = c_s4; end
			default:     begin r_c = c_s4; g_c = m_s4; b_c = x_c;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		h_s1 <= hue_c;
		s_s1 <= sat_c;
		v_s1 <= val_c;

		sec_s2 <= sec_c;
		pos_s2 <= h_s1 - base_c;
		p_s2   <= PW'(v_s1) * PW'(s_s1);
		v_s2   <= v_s1;

		sec_s3  <= sec_s2;
		dist_s3 <= dist_c;
		p_s3    <= p_s2;
		v_s3    <= v_s2;
		c_s3    <= c_full_c[UNIT_FRAC_BITS+7:UNIT_FRAC_BITS];
		m_s3    <= m_full_c[2*UNIT_FRAC_BITS+7:2*UNIT_FRAC_BITS];

		sec_s4 <= sec_s3;
		q_s4   <= NW'(p_s3) * NW'(dist_s3);
		vw_s4  <= (NW'(v_s3) * NW'(SECTOR_W)) << UNIT_FRAC_BITS;
		c_s4   <= c_s3;
		m_s4   <= m_s3;

		red_s5   <= r_c;
		green_s5 <= g_c;
		blue_s5  <= b_c;
	end

	assign busy  = 1'b0;
	assign done  = vld_s5;
	assign red   = red_s5;
	assign green = green_s5;
	assign blue  = blue_s5;

	// a taken word comes out on done after passing through every stage register
	`HSV_ASSERT_IMP(a_latency, start && !busy, ##5 done)
	// offset channel never exceeds the chroma channel
	`HSV_ASSERT_IMP(a_offset_le_chroma, vld_s3, m_s3 <= c_s3)
	// secondary numerator cannot underflow
	`HSV_ASSERT_IMP(a_no_underflow, vld_s4, q_s4 <= vw_s4)

endmodule

// ===== tb/sv/hsv_to_rgb_converter_core_chk.sv =====
`timescale 1ns / 1ps
// Scoreboard for the HSV to RGB converter core: predicts the color of every accepted word
// and checks it against the next done strobe. Depends on hsv2rgb_pkg.sv.

module hsv_to_rgb_converter_core_chk #(
	parameter int HUE_FRAC_BITS  = 6,
	parameter int UNIT_FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [HUE_FRAC_BITS+8:0]       hue,
	input  logic [UNIT_FRAC_BITS:0]        saturation,
	input  logic [UNIT_FRAC_BITS:0]        brightness,
	input  logic                           done,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] red,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] green,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] blue,
	output int                             words_owed,
	output int                             fail_count
);

	import hsv2rgb_pkg::*;

	localparam longint unsigned UNIT_ONE  = 64'd1 << UNIT_FRAC_BITS;
	localparam longint unsigned SECTOR_W  = 64'd60 << HUE_FRAC_BITS;
	localparam longint unsigned HUE_FULL  = 64'd360 << HUE_FRAC_BITS;
	localparam longint unsigned FULL_SPAN = UNIT_ONE * UNIT_ONE * SECTOR_W;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

	rgb_t color_q[$];
	int   mismatches;

	// channel in units of 1/FULL_SPAN -> floor(255 * fraction)
	function automatic logic [CHAN_W-1:0] channel_level(input longint unsigned scaled);
		longint unsigned q;
		q = (scaled * 64'(SCALE_FULL)) / FULL_SPAN;
		if (q > 64'(SCALE_FULL))
			q = 64'(SCALE_FULL);
		return q[CHAN_W-1:0];
	endfunction

	function automatic rgb_t hsv_pixel_color(
		input logic [HUE_FRAC_BITS+8:0] h_in,
		input logic [UNIT_FRAC_BITS:0]  s_in,
		input logic [UNIT_FRAC_BITS:0]  v_in
	);
		longint unsigned h, s, v, sec, pos, gap, cw, xw, mw;
		longint unsigned ch0, ch1, ch2;
		rgb_t px;
		h = 64'(h_in);
		s = 64'(s_in);
		v = 64'(v_in);
		if (s > UNIT_ONE)
			s = UNIT_ONE;
		if (v > UNIT_ONE)
			v = UNIT_ONE;
		if (h >= HUE_FULL)
			h = h - HUE_FULL;
		sec = h / SECTOR_W;
		if (sec > 5)
			sec = 5;
		pos = h - (sec >> 1) * (2 * SECTOR_W);
		gap = (pos >= SECTOR_W) ? pos - SECTOR_W : SECTOR_W - pos;
		if (gap > SECTOR_W)
			gap = SECTOR_W;
		cw = v * s * SECTOR_W;
		xw = v * s * (SECTOR_W - gap);
		mw = (v * UNIT_ONE - v * s) * SECTOR_W;
		ch0 = mw;
		ch1 = mw;
		ch2 = mw;
		case (sector_t'(sec[2:0]))
			SEC_RED_YEL: begin ch0 += cw; ch1 += xw; end
			SEC_YEL_GRN: begin ch1 += cw; ch0 += xw; end
			SEC_GRN_CYN: begin ch1 += cw; ch2 += xw; end
			SEC_CYN_BLU: begin ch2 += cw; ch1 += xw; end
			SEC_BLU_MAG: begin ch2 += cw; ch0 += xw; end
			SEC_MAG_RED: begin ch0 += cw; ch2 += xw; end
			default: begin end
		endcase
		px.r = channel_level(ch0);
		px.g = channel_level(ch1);
		px.b = channel_level(ch2);
		return px;
	endfunction

	task automatic flag_channel(input string name, input logic [CHAN_W-1:0] want,
		input logic [CHAN_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rgb_t want;
		if (!arst_n) begin
			color_q.delete();
			mismatches = 0;
			words_owed <= 0;
			fail_count <= 0;
		end else begin
			if (done) begin
				if (color_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, expected none, got %0d/%0d/%0d",
						$time, red, green, blue);
				end else begin
					want = color_q.pop_front();
					flag_channel("red", want.r, red);
					flag_channel("green", want.g, green);
					flag_channel("blue", want.b, blue);
				end
			end
			if (start && !busy)
				color_q.push_back(hsv_pixel_color(hue, saturation, brightness));
			words_owed <= color_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ===== tb/sv/hsv_to_rgb_converter_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the HSV to RGB converter core bench: clock, reset, word stimulus and verdict.
// Depends on hsv2rgb_pkg.sv, hsv_to_rgb_converter_core.sv and hsv_to_rgb_converter_core_chk.sv.

module hsv_to_rgb_converter_core_tb;

	import hsv2rgb_pkg::*;

	localparam int HFB = 6;
	localparam int UFB = 8;
	// hue units per 60-degree sector and per full turn
	localparam int SECTOR_W = 60 << HFB;
	localparam int HUE_FULL = 360 << HFB;
	localparam int HUE_MAX  = (1 << (HFB + 9)) - 1;
	localparam int UNIT_ONE = 1 << UFB;
	localparam int UNIT_MAX = (1 << (UFB + 1)) - 1;

	localparam int N_RANDOM    = 1900;
	// final stretch runs back to back with no gaps
	localparam int N_TAIL      = 300;
	// pipeline is five stages deep; settle a few more after the last done
	localparam int SETTLE      = 12;
	// worst case: every word after the longest gap, plus reset and drains
	localparam int CYCLE_LIMIT = 300000;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [HFB+8:0]      hue;
	logic [UFB:0]        saturation;
	logic [UFB:0]        brightness;
	logic                done;
	logic [CHAN_W-1:0]   red;
	logic [CHAN_W-1:0]   green;
	logic [CHAN_W-1:0]   blue;
	int                  words_owed;
	int                  fail_count;
	int unsigned         cycle_count = 0;
	bit                  gaps_on;

	hsv_to_rgb_converter_core #(
		.HUE_FRAC_BITS (HFB),
		.UNIT_FRAC_BITS(UFB)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.done      (done),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// scoreboard sits beside the DUT and only watches the ports
	hsv_to_rgb_converter_core_chk #(
		.HUE_FRAC_BITS (HFB),
		.UNIT_FRAC_BITS(UFB)
	) i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.done      (done),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.words_owed(words_owed),
		.fail_count(fail_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: a hung handshake or lost result ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("hsv_to_rgb_converter_core verification failed");
			$finish;
		end
	end

	// Present one word at a falling edge and hold it until a rising edge
	// takes it (start high, busy low). Returns on the next falling edge,
	// where the caller either offers the next word or drops start.
	task automatic send_word(input int h, input int s, input int v);
		start      <= 1'b1;
		hue        <= (HFB + 9)'(h);
		saturation <= (UFB + 1)'(s);
		brightness <= (UFB + 1)'(v);
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Drop start and wait until every predicted color has come out.
	task automatic drain_pipe();
		start <= 1'b0;
		while (words_owed != 0)
			@(negedge clk);
	endtask

	// Random hue: mostly the legal circle, some hits right on the sector
	// edges, and some over the whole field to exercise the wrap and the top bits.
	function automatic int pick_hue();
		int k;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 17)
			return $urandom_range(0, HUE_FULL - 1);
		if (sel == 17) begin
			k = $urandom_range(0, 5) * SECTOR_W + $urandom_range(0, 2);
			return (k == 0) ? 0 : k - 1;
		end
		return $urandom_range(0, HUE_MAX);
	endfunction

	// Random fraction: mostly 0..1.0, sometimes pinned at 0 or 1.0,
	// sometimes above 1.0 so the clamp gets hit and the top bit toggles.
	function automatic int pick_unit();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 8)
			return $urandom_range(0, UNIT_ONE);
		if (sel == 8)
			return ($urandom_range(0, 1) != 0) ? UNIT_ONE : 0;
		return $urandom_range(UNIT_ONE + 1, UNIT_MAX);
	endfunction

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		hue         = '0;
		saturation  = '0;
		brightness  = '0;
		gaps_on     = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words, back to back: primaries and secondaries on the
		// exact sector edges, mid-sector points, hue wrap past 360 degrees,
		// clamp of saturation and value above 1.0, gray and black.
		send_word(0, UNIT_ONE, UNIT_ONE);
		send_word(SECTOR_W, UNIT_ONE, UNIT_ONE);
		send_word(2 * SECTOR_W, UNIT_ONE, UNIT_ONE);
		send_word(3 * SECTOR_W, UNIT_ONE, UNIT_ONE);
		send_word(4 * SECTOR_W, UNIT_ONE, UNIT_ONE);
		send_word(5 * SECTOR_W, UNIT_ONE, UNIT_ONE);
		send_word(SECTOR_W - 1, UNIT_ONE, UNIT_ONE);
		send_word(3 * SECTOR_W - 1, UNIT_ONE, UNIT_ONE);
		send_word(5 * SECTOR_W - 1, 200, 200);
		send_word(SECTOR_W / 2, UNIT_ONE, UNIT_ONE);
		send_word(HUE_FULL - 1, UNIT_ONE, UNIT_ONE);
		send_word(HUE_FULL, UNIT_ONE, UNIT_ONE);
		send_word(HUE_MAX, UNIT_ONE, UNIT_ONE);
		send_word(5000, 0, UNIT_ONE);
		send_word(5000, UNIT_ONE, 0);
		send_word(0, 0, 0);
		send_word(12345, UNIT_ONE + 1, UNIT_ONE);
		send_word(12345, UNIT_MAX, UNIT_MAX);
		send_word(9000, UNIT_ONE / 2, UNIT_MAX);
		send_word(17000, UNIT_MAX, 100);
		send_word(6000, 1, 1);
		send_word(21000, UNIT_ONE - 1, UNIT_ONE - 1);
		send_word(100, UNIT_ONE, 1);
		drain_pipe();

		// Random words. Idle gaps between words are switched on and off
		// in stretches; the tail runs at full rate.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 150 == 0)
				gaps_on = ($urandom_range(0, 2) != 0);
			if (i >= N_RANDOM - N_TAIL)
				gaps_on = 1'b0;
			// one full stop mid-run: let the pipe empty before going on
			if (i == N_RANDOM / 2)
				drain_pipe();
			send_word(pick_hue(), pick_unit(), pick_unit());
			if (gaps_on && $urandom_range(0, 4) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
		end
		drain_pipe();
		repeat (SETTLE) @(negedge clk);

		if (fail_count == 0)
			$display("hsv_to_rgb_converter_core verification clean");
		else
			$display("hsv_to_rgb_converter_core verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/hsv2rgb_pkg.sv
design/hsv_to_rgb_converter_core.sv
tb/sv/hsv_to_rgb_converter_core_chk.sv
tb/sv/hsv_to_rgb_converter_core_tb.sv
